[sv/cvc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cvc_pkg
// Shared constants, register codes and transaction types for the clamped
// valid-region 2-D convolution block.
// ----------------------------------------------------------------------------
package cvc_pkg;

   // Defaults for the top-level parameters.
   localparam int DEF_MAX_WIDTH      = 1024;
   localparam int DEF_MAX_KERNEL     = 7;
   localparam int DEF_COEF_FRAC_BITS = 12;
   localparam int QUEUE_DEPTH        = 4;

   // Field widths sized for the largest parameter values supported.
   localparam int WIDTH_BITS_MAX  = 13;
   localparam int HEIGHT_BITS     = 11;
   localparam int KER_BITS_MAX    = 4;
   localparam int COL_BITS_MAX    = 12;
   localparam int SLOT_BITS_MAX   = 4;
   localparam int PIXEL_BITS      = 8;
   localparam int COEF_BITS       = 16;
   localparam int PROD_BITS       = PIXEL_BITS + 1 + COEF_BITS;
   localparam int CSR_DATA_BITS   = 11;
   localparam int CSR_INDEX_BITS  = 2;
   localparam int COEF_INDEX_BITS = 6;
   localparam int FIELD_KER_BITS  = 3;

   // Request kinds.
   localparam logic REQ_PIXEL = 1'b0;
   localparam logic REQ_COEF  = 1'b1;

   // Configuration register indexes.
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_IMAGE_WIDTH  = 2'd0,
      CSR_IMAGE_HEIGHT = 2'd1,
      CSR_KERNEL_ROWS  = 2'd2,
      CSR_KERNEL_COLS  = 2'd3
   } cvc_csr_index_type;

   // Clamped configuration as seen by the front and back parts.
   typedef struct packed {
      logic [WIDTH_BITS_MAX-1:0] width;
      logic [HEIGHT_BITS-1:0]    height;
      logic [KER_BITS_MAX-1:0]   krows;
      logic [KER_BITS_MAX-1:0]   kcols;
   } cvc_cfg_type;

   // One classified transaction passed from the front to the back.
   typedef struct packed {
      logic                         is_coef;
      logic                         coef_ok;
      logic [PIXEL_BITS-1:0]        pixel;
      logic signed [COEF_BITS-1:0]  coef;
      logic [KER_BITS_MAX-1:0]      coef_row;
      logic [KER_BITS_MAX-1:0]      coef_col;
      logic [COL_BITS_MAX-1:0]      col;
      logic [SLOT_BITS_MAX-1:0]     slot;
      logic                         emit;
      logic                         last;
   } cvc_item_type;

endpackage

[sv/valid_2d_convolution_clamped.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// valid_2d_convolution_clamped
// Streaming 2-D correlation of a grey pixel raster with a loaded kernel,
// giving clamped results for the valid region only.
// ----------------------------------------------------------------------------
// Usage:
// The req_ channel carries pixel transactions in raster order and
// coefficient write transactions, mixed in one stream; req_type selects.
// The rsp_ channel carries one result per pixel whose window lies wholly
// inside the frame, with rsp_out_last set on the last result of a frame.
// The csr_ port writes image width, image height, kernel rows and kernel
// columns; write it only while the block is idle.
// From acceptance of a pixel to rsp_valid, when nothing stalls, a result
// passes the queue read together with the line store read, the window,
// the multipliers, the row sums and the total of the adder tree, and
// rounding and clamping into the response register.
// Throughput is one transaction per cycle while the receiver does not stall,
// set by the single-port line store word that holds every stored row of one
// column. When the receiver stalls, the whole back pipeline holds, the queue
// fills and req_ready drops once it is full.
// Reset clears the window, the coefficients, the raster position and the
// registers to 512 by 512 with a 3 by 3 kernel; the line store is not
// cleared and needs none, since a row is always written before it is read.
// ----------------------------------------------------------------------------
module valid_2d_convolution_clamped #(
   parameter int MAX_WIDTH      = cvc_pkg::DEF_MAX_WIDTH,
   parameter int MAX_KERNEL     = cvc_pkg::DEF_MAX_KERNEL,
   parameter int COEF_FRAC_BITS = cvc_pkg::DEF_COEF_FRAC_BITS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_type,
   input  logic [cvc_pkg::PIXEL_BITS-1:0]       req_pixel_value,
   input  logic [cvc_pkg::COEF_INDEX_BITS-1:0]  req_coef_index,
   input  logic signed [cvc_pkg::COEF_BITS-1:0] req_coef_value,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [cvc_pkg::PIXEL_BITS-1:0]       rsp_out_pixel,
   output logic                                 rsp_out_last,
   input  logic                                 csr_write,
   input  logic [cvc_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [cvc_pkg::CSR_DATA_BITS-1:0]    csr_data
);
   import cvc_pkg::*;

   cvc_cfg_type  cfg_ff, cfg_in;
   cvc_item_type push_item, head;
   logic         push, queue_full, queue_empty, pop;
   logic [FIELD_KER_BITS-1:0] ker_value;

   assign ker_value = csr_data[FIELD_KER_BITS-1:0];

   // Register writes, clamped to the usable range.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (cvc_csr_index_type'(csr_index))
            CSR_IMAGE_WIDTH: begin
               if (csr_data == '0) begin
                  cfg_in.width = WIDTH_BITS_MAX'(1);
               end else if (WIDTH_BITS_MAX'(csr_data) > WIDTH_BITS_MAX'(MAX_WIDTH)) begin
                  cfg_in.width = WIDTH_BITS_MAX'(MAX_WIDTH);
               end else begin
                  cfg_in.width = WIDTH_BITS_MAX'(csr_data);
               end
            end
            CSR_IMAGE_HEIGHT: begin
               cfg_in.height = (csr_data == '0) ? HEIGHT_BITS'(1) : HEIGHT_BITS'(csr_data);
            end
            CSR_KERNEL_ROWS: begin
               if (ker_value == '0) begin
                  cfg_in.krows = KER_BITS_MAX'(1);
               end else if (KER_BITS_MAX'(ker_value) > KER_BITS_MAX'(MAX_KERNEL)) begin
                  cfg_in.krows = KER_BITS_MAX'(MAX_KERNEL);
               end else begin
                  cfg_in.krows = KER_BITS_MAX'(ker_value);
               end
            end
            CSR_KERNEL_COLS: begin
               if (ker_value == '0) begin
                  cfg_in.kcols = KER_BITS_MAX'(1);
               end else if (KER_BITS_MAX'(ker_value) > KER_BITS_MAX'(MAX_KERNEL)) begin
                  cfg_in.kcols = KER_BITS_MAX'(MAX_KERNEL);
               end else begin
                  cfg_in.kcols = KER_BITS_MAX'(ker_value);
               end
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.width  <= (MAX_WIDTH < 512) ? WIDTH_BITS_MAX'(MAX_WIDTH) : WIDTH_BITS_MAX'(512);
         cfg_ff.height <= HEIGHT_BITS'(512);
         cfg_ff.krows  <= (MAX_KERNEL < 3) ? KER_BITS_MAX'(MAX_KERNEL) : KER_BITS_MAX'(3);
         cfg_ff.kcols  <= (MAX_KERNEL < 3) ? KER_BITS_MAX'(MAX_KERNEL) : KER_BITS_MAX'(3);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   cvc_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_KERNEL (MAX_KERNEL)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_type        (req_type),
      .req_pixel_value (req_pixel_value),
      .req_coef_index  (req_coef_index),
      .req_coef_value  (req_coef_value),
      .queue_full      (queue_full),
      .push            (push),
      .push_item       (push_item)
   );

   cvc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (queue_full),
      .pop       (pop),
      .empty     (queue_empty),
      .head      (head)
   );

   cvc_back #(
      .MAX_WIDTH      (MAX_WIDTH),
      .MAX_KERNEL     (MAX_KERNEL),
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .queue_empty   (queue_empty),
      .head          (head),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_pixel (rsp_out_pixel),
      .rsp_out_last  (rsp_out_last)
   );

endmodule

[sv/cvc_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cvc_queue
// Short first-in first-out queue of classified transactions between the
// front and the back.
// ----------------------------------------------------------------------------
module cvc_queue #(
   parameter int DEPTH = cvc_pkg::QUEUE_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  cvc_pkg::cvc_item_type push_item,
   output logic                  full,
   input  logic                  pop,
   output logic                  empty,
   output cvc_pkg::cvc_item_type head
);
   import cvc_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   cvc_item_type   slots_ff [DEPTH];
   logic [PW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]  count_ff, count_in;
   logic           do_push, do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign head    = slots_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   // Pointer and fill-count update with wrap at the queue depth.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Payload storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

[sv/cvc_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cvc_front
// Accepts request transactions, tracks the raster position and decodes
// coefficient indexes into kernel row and column.
// ----------------------------------------------------------------------------
module cvc_front #(
   parameter int MAX_WIDTH  = cvc_pkg::DEF_MAX_WIDTH,
   parameter int MAX_KERNEL = cvc_pkg::DEF_MAX_KERNEL
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  cvc_pkg::cvc_cfg_type                    cfg,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic                                    req_type,
   input  logic [cvc_pkg::PIXEL_BITS-1:0]          req_pixel_value,
   input  logic [cvc_pkg::COEF_INDEX_BITS-1:0]     req_coef_index,
   input  logic signed [cvc_pkg::COEF_BITS-1:0]    req_coef_value,
   input  logic                                    queue_full,
   output logic                                    push,
   output cvc_pkg::cvc_item_type                   push_item
);
   import cvc_pkg::*;

   localparam int LINES = (MAX_KERNEL > 1) ? MAX_KERNEL - 1 : 1;
   localparam int CW    = $clog2(MAX_WIDTH + 1);
   localparam int SW    = (LINES > 1) ? $clog2(LINES) : 1;
   localparam int KW    = $clog2(MAX_KERNEL + 1);
   localparam int TW    = (2 * KW + 1 > COEF_INDEX_BITS) ? 2 * KW + 1 : COEF_INDEX_BITS;

   logic [CW-1:0]          col_ff, col_in;
   logic [HEIGHT_BITS-1:0] row_ff, row_in;
   logic [SW-1:0]          slot_ff, slot_in;
   logic [CW-1:0]          cur_col;
   logic [HEIGHT_BITS-1:0] cur_row;
   logic [SW-1:0]          cur_slot;
   logic [CW-1:0]          width;
   logic [KW-1:0]          krows, kcols;
   logic [KW-1:0]          qrow;
   logic [TW-1:0]          qcol;
   logic                   accept_pixel;

   assign width        = cfg.width[CW-1:0];
   assign krows        = cfg.krows[KW-1:0];
   assign kcols        = cfg.kcols[KW-1:0];
   assign req_ready    = !queue_full;
   assign push         = req_valid && !queue_full;
   assign accept_pixel = push && (req_type == REQ_PIXEL);

   // Position of this pixel, after a size change has been folded in.
   always_comb begin
      cur_col  = col_ff;
      cur_row  = row_ff;
      cur_slot = slot_ff;
      if (col_ff >= width) begin
         cur_col  = '0;
         cur_row  = row_ff + 1'b1;
         cur_slot = (slot_ff == SW'(LINES - 1)) ? '0 : slot_ff + 1'b1;
      end
      if (cur_row >= cfg.height) begin
         cur_row  = '0;
         cur_slot = '0;
      end
   end

   // Position of the next pixel.
   always_comb begin
      col_in  = cur_col + 1'b1;
      row_in  = cur_row;
      slot_in = cur_slot;
      if (col_in >= width) begin
         col_in  = '0;
         row_in  = cur_row + 1'b1;
         slot_in = (cur_slot == SW'(LINES - 1)) ? '0 : cur_slot + 1'b1;
         if (row_in >= cfg.height) begin
            row_in  = '0;
            slot_in = '0;
         end
      end
   end

   // Quotient and remainder of the coefficient index by the kernel width,
   // found by comparing against each multiple of the width.
   always_comb begin
      logic [TW-1:0] multiple;
      qrow = '0;
      for (int k = 1; k <= MAX_KERNEL; k++) begin
         multiple = TW'(k) * TW'(kcols);
         if (multiple <= TW'(req_coef_index)) begin
            qrow = qrow + 1'b1;
         end
      end
      qcol = TW'(req_coef_index) - TW'(qrow) * TW'(kcols);
   end

   // Classified transaction for the queue.
   always_comb begin
      push_item          = '0;
      push_item.is_coef  = (req_type == REQ_COEF);
      push_item.coef_ok  = (qrow < KW'(MAX_KERNEL));
      push_item.pixel    = req_pixel_value;
      push_item.coef     = req_coef_value;
      push_item.coef_row = KER_BITS_MAX'(qrow);
      push_item.coef_col = KER_BITS_MAX'(qcol);
      push_item.col      = COL_BITS_MAX'(cur_col);
      push_item.slot     = SLOT_BITS_MAX'(cur_slot);
      push_item.emit     = ({1'b0, cur_row} + 1'b1 >= (HEIGHT_BITS + 1)'(krows)) &&
                           ({1'b0, cur_col} + 1'b1 >= (CW + 1)'(kcols));
      push_item.last     = ({1'b0, cur_row} + 1'b1 == {1'b0, cfg.height}) &&
                           ({1'b0, cur_col} + 1'b1 == {1'b0, width});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         slot_ff <= '0;
      end else if (accept_pixel) begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         slot_ff <= slot_in;
      end
   end

endmodule

[sv/cvc_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cvc_back
// Line store, window, coefficient store, multiply and adder-tree pipeline
// with rounding, clamping and the response register.
// ----------------------------------------------------------------------------
module cvc_back #(
   parameter int MAX_WIDTH      = cvc_pkg::DEF_MAX_WIDTH,
   parameter int MAX_KERNEL     = cvc_pkg::DEF_MAX_KERNEL,
   parameter int COEF_FRAC_BITS = cvc_pkg::DEF_COEF_FRAC_BITS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  cvc_pkg::cvc_cfg_type             cfg,
   input  logic                             queue_empty,
   input  cvc_pkg::cvc_item_type            head,
   output logic                             pop,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [cvc_pkg::PIXEL_BITS-1:0]   rsp_out_pixel,
   output logic                             rsp_out_last
);
   import cvc_pkg::*;

   localparam int LINES = (MAX_KERNEL > 1) ? MAX_KERNEL - 1 : 1;
   localparam int AW    = $clog2(MAX_WIDTH);
   localparam int SW    = (LINES > 1) ? $clog2(LINES) : 1;
   localparam int KW    = $clog2(MAX_KERNEL + 1);
   localparam int KIW   = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
   localparam int RW    = PROD_BITS + KW;
   localparam int TW    = PROD_BITS + 2 * KW;
   localparam logic signed [TW:0] HALF = (TW + 1)'(1) <<< (COEF_FRAC_BITS - 1);

   logic [LINES*PIXEL_BITS-1:0] line_mem [MAX_WIDTH];
   logic [LINES*PIXEL_BITS-1:0] rd_ff;

   logic                         s1_valid_ff;
   cvc_item_type                 s1_item_ff;
   logic [PIXEL_BITS-1:0]        win_ff [MAX_KERNEL][MAX_KERNEL];
   logic [PIXEL_BITS-1:0]        win_in [MAX_KERNEL][MAX_KERNEL];
   logic [PIXEL_BITS-1:0]        new_pix [MAX_KERNEL];
   logic signed [COEF_BITS-1:0]  coef_ff [MAX_KERNEL][MAX_KERNEL];
   logic signed [PROD_BITS-1:0]  prod_ff [MAX_KERNEL][MAX_KERNEL];
   logic signed [RW-1:0]         rsum_ff [MAX_KERNEL];
   logic signed [RW-1:0]         rsum_in [MAX_KERNEL];
   logic signed [TW-1:0]         total_ff, total_in;
   logic                         s2_emit_ff, s3_emit_ff, s4_emit_ff, s5_emit_ff;
   logic                         s2_last_ff, s3_last_ff, s4_last_ff, s5_last_ff;
   logic                         rsp_valid_ff;
   logic [PIXEL_BITS-1:0]        out_pixel_ff, out_pixel_in;
   logic                         out_last_ff;
   logic [KW-1:0]                krows, kcols;
   logic                         advance;
   logic                         s1_pixel, s1_coef;

   assign krows    = cfg.krows[KW-1:0];
   assign kcols    = cfg.kcols[KW-1:0];
   assign advance  = !rsp_valid_ff || rsp_ready;
   assign pop      = advance && !queue_empty;
   assign s1_pixel = s1_valid_ff && !s1_item_ff.is_coef;
   assign s1_coef  = s1_valid_ff && s1_item_ff.is_coef && s1_item_ff.coef_ok;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_pixel = out_pixel_ff;
   assign rsp_out_last  = out_last_ff;

   // Line store: one word per column holds that column of every stored row.
   // The read returns the word as it was before this transaction's write.
   always_ff @(posedge clock) begin
      if (advance) begin
         rd_ff <= line_mem[head.col[AW-1:0]];
      end
      if (pop && !head.is_coef) begin
         line_mem[head.col[AW-1:0]][head.slot[SW-1:0]*PIXEL_BITS +: PIXEL_BITS] <= head.pixel;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_item_ff <= head;
      end
   end

   // New right-hand column of the window: the current pixel for the bottom
   // kernel row, older rows from the line store.
   always_comb begin
      logic [KW-1:0] gap;
      logic [SW-1:0] src;
      for (int i = 0; i < MAX_KERNEL; i++) begin
         gap = KW'(int'(krows) - 1 - i);
         if (int'(s1_item_ff.slot[SW-1:0]) >= int'(gap)) begin
            src = SW'(int'(s1_item_ff.slot[SW-1:0]) - int'(gap));
         end else begin
            src = SW'(int'(s1_item_ff.slot[SW-1:0]) + LINES - int'(gap));
         end
         if (gap == '0) begin
            new_pix[i] = s1_item_ff.pixel;
         end else begin
            new_pix[i] = rd_ff[src*PIXEL_BITS +: PIXEL_BITS];
         end
      end
   end

   // Shift the active part of the window left by one column.
   always_comb begin
      win_in = win_ff;
      for (int i = 0; i < MAX_KERNEL; i++) begin
         for (int j = 0; j < MAX_KERNEL; j++) begin
            if (i < int'(krows)) begin
               if (j + 1 < int'(kcols)) begin
                  win_in[i][j] = win_ff[i][(j + 1) % MAX_KERNEL];
               end else if (j + 1 == int'(kcols)) begin
                  win_in[i][j] = new_pix[i];
               end
            end
         end
      end
   end

   // Window and coefficient store, both cleared at reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_KERNEL; i++) begin
            for (int j = 0; j < MAX_KERNEL; j++) begin
               win_ff[i][j]  <= '0;
               coef_ff[i][j] <= '0;
            end
         end
      end else if (advance) begin
         if (s1_pixel) begin
            win_ff <= win_in;
         end
         if (s1_coef) begin
            coef_ff[s1_item_ff.coef_row[KIW-1:0]][s1_item_ff.coef_col[KIW-1:0]] <=
               s1_item_ff.coef;
         end
      end
   end

   // One multiplier per window position; positions outside the kernel give zero.
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < MAX_KERNEL; i++) begin
            for (int j = 0; j < MAX_KERNEL; j++) begin
               if (i < int'(krows) && j < int'(kcols)) begin
                  prod_ff[i][j] <= PROD_BITS'($signed({1'b0, win_ff[i][j]}) * coef_ff[i][j]);
               end else begin
                  prod_ff[i][j] <= '0;
               end
            end
         end
      end
   end

   // First tree level: one sum per kernel row.
   always_comb begin
      for (int i = 0; i < MAX_KERNEL; i++) begin
         rsum_in[i] = '0;
         for (int j = 0; j < MAX_KERNEL; j++) begin
            rsum_in[i] = rsum_in[i] + RW'(prod_ff[i][j]);
         end
      end
   end

   // Second tree level: sum of the row sums.
   always_comb begin
      total_in = '0;
      for (int i = 0; i < MAX_KERNEL; i++) begin
         total_in = total_in + TW'(rsum_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsum_ff  <= rsum_in;
         total_ff <= total_in;
      end
   end

   // Round to nearest with ties upward, then clamp to full scale.
   always_comb begin
      logic signed [TW:0] rounded;
      logic signed [TW:0] scaled;
      rounded = {total_ff[TW-1], total_ff} + HALF;
      scaled  = rounded >>> COEF_FRAC_BITS;
      if (total_ff <= 0) begin
         out_pixel_in = '0;
      end else if (scaled > (TW + 1)'(255)) begin
         out_pixel_in = '1;
      end else begin
         out_pixel_in = scaled[PIXEL_BITS-1:0];
      end
   end

   // Pipeline control and the response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_emit_ff   <= 1'b0;
         s3_emit_ff   <= 1'b0;
         s4_emit_ff   <= 1'b0;
         s5_emit_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= !queue_empty;
         s2_emit_ff   <= s1_pixel && s1_item_ff.emit;
         s3_emit_ff   <= s2_emit_ff;
         s4_emit_ff   <= s3_emit_ff;
         s5_emit_ff   <= s4_emit_ff;
         rsp_valid_ff <= s5_emit_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_last_ff   <= s1_item_ff.last;
         s3_last_ff   <= s2_last_ff;
         s4_last_ff   <= s3_last_ff;
         s5_last_ff   <= s4_last_ff;
         out_last_ff  <= s5_last_ff;
         out_pixel_ff <= out_pixel_in;
      end
   end

endmodule

[sv/cvc_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cvc_checker
// Port-level checks for the convolution block, bound to the top level.
// ----------------------------------------------------------------------------
module cvc_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_ready,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic [cvc_pkg::PIXEL_BITS-1:0]     rsp_out_pixel,
   input logic                               rsp_out_last
);
   import cvc_pkg::*;

   // A stalled response holds its value and its payload.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_out_pixel) &&
                                     $stable(rsp_out_last)))
      else $error("stalled response changed");

   // Reset leaves no response pending.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response pending right after reset");

   // The queue is empty after reset, so requests are taken at once.
   assert property (@(posedge clock) $fell(reset) |-> req_ready)
      else $error("request side not ready after reset");

   // A response needs the pipeline to fill, so none appears right after reset.
   assert property (@(posedge clock) disable iff (reset)
      $fell(reset) |-> ##1 !rsp_valid)
      else $error("response appeared before the pipeline could fill");

endmodule

bind valid_2d_convolution_clamped cvc_checker u_cvc_checker (
   .clock         (clock),
   .reset         (reset),
   .req_ready     (req_ready),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_out_pixel (rsp_out_pixel),
   .rsp_out_last  (rsp_out_last)
);
